@@ rtl/srtf_pkg.sv @@
// srtf_pkg: widths, constants and shared types of the SRTF scheduler.
// Used by srtf_cell and srtf_scheduler; depends on nothing else.
package srtf_pkg;

    localparam int SLOTS   = 16;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int LABEL_W = 8;
    localparam int VAL_W   = 16;
    localparam int TIME_W  = 21;
    localparam int NPROC_W = 5;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [TIME_W-1:0]  TIME_MAX      = {TIME_W{1'b1}};
    localparam logic [NPROC_W-1:0] NPROC_RESET   = NPROC_W'(16);
    localparam logic [CNT_W-1:0]   SLOTS_CNT     = CNT_W'(SLOTS);
    localparam logic [ADDR_W-1:0]  ADDR_NUM_PROC = ADDR_W'(0);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Best candidate so far, handed from cell to cell during a scan
    typedef struct packed {
        logic               found;
        logic [SLOT_W-1:0]  slot;
        logic [VAL_W-1:0]   rem;
        logic [LABEL_W-1:0] label;
        logic [VAL_W-1:0]   arrival;
        logic [VAL_W-1:0]   burst;
        logic [CNT_W-1:0]   undone;   // participating slots not yet done
    } cand_t;

    // Controls broadcast from the top level to every cell
    typedef struct packed {
        logic               wr_en;
        logic [SLOT_W-1:0]  wr_slot;
        logic [LABEL_W-1:0] wr_label;
        logic [VAL_W-1:0]   wr_arrival;
        logic [VAL_W-1:0]   wr_burst;
        logic               run_en;
        logic [SLOT_W-1:0]  run_slot;
        logic [TIME_W-1:0]  time_now;
        logic [CNT_W-1:0]   active_cnt;
    } cell_ctl_t;

endpackage

@@ rtl/srtf_cell.sv @@
// srtf_cell: one task slot of the scheduler chain plus its stage of the
// minimum-remaining-time scan. Depends on srtf_pkg.
module srtf_cell
    import srtf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] my_idx,
    input  cell_ctl_t         ctl,
    input  cand_t             cand_in,
    output cand_t             cand_out
);

    logic [LABEL_W-1:0] label_reg;
    logic [VAL_W-1:0]   arrival_reg;
    logic [VAL_W-1:0]   burst_reg;
    logic [VAL_W-1:0]   rem_reg;
    logic               done_reg;
    cand_t              cand_reg;
    cand_t              cand_next;

    logic wr_hit;
    logic run_hit;
    logic participate;
    logic eligible;
    logic take;

    assign wr_hit  = ctl.wr_en && (ctl.wr_slot == my_idx);
    assign run_hit = ctl.run_en && (ctl.run_slot == my_idx);

    // Task payload, written by a load
    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            label_reg   <= ctl.wr_label;
            arrival_reg <= ctl.wr_arrival;
            burst_reg   <= ctl.wr_burst;
        end
    end

    // Remaining time and done mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (wr_hit)
        begin
            rem_reg  <= ctl.wr_burst;
            done_reg <= 1'b0;
        end
        else if (run_hit)
        begin
            rem_reg <= rem_reg - VAL_W'(1);
            if (rem_reg == VAL_W'(1))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // Scan stage: keep the incoming candidate unless this slot beats it
    assign participate = ({1'b0, my_idx} < ctl.active_cnt);
    assign eligible = participate && !done_reg && (rem_reg != '0) &&
                      ({{(TIME_W - VAL_W){1'b0}}, arrival_reg} <= ctl.time_now);
    assign take = eligible && (!cand_in.found || (rem_reg < cand_in.rem));

    always_comb
    begin
        cand_next = cand_in;
        if (take)
        begin
            cand_next.found   = 1'b1;
            cand_next.slot    = my_idx;
            cand_next.rem     = rem_reg;
            cand_next.label   = label_reg;
            cand_next.arrival = arrival_reg;
            cand_next.burst   = burst_reg;
        end
        cand_next.undone = cand_in.undone + CNT_W'(participate && !done_reg);
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
    end

    assign cand_out = cand_reg;

endmodule

@@ rtl/srtf_scheduler.sv @@
// srtf_scheduler: top level of the SRTF scheduler: APB register, control
// sequencer, chain of srtf_cell slots and result register. Uses srtf_pkg.
//
//   channel   signals                                   direction
//   input     in_valid/in_ready, cmd slot task_label    in
//             arrival burst
//   output    out_valid/out_ready, ran ran_slot ...     out
//             time_after
//   config    psel penable pwrite paddr pwdata          in
//             prdata pready                             out
//
// Every transaction steps through ST_IDLE to accept it, ST_SCAN while the
// candidate ripples through the cell chain, and ST_FIN to update the winning
// slot and load the result register.
// A new transaction is taken while a result still waits in the output
// register; the sequencer holds in its final step while that register is full.
// Reset (rst_n, asynchronous) clears remaining times, done marks, time and
// sets num_processes to 16; task payloads are undefined until loaded.
module srtf_scheduler
    import srtf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // input channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                cmd,
    input  logic [3:0]          slot,
    input  logic [7:0]          task_label,
    input  logic [15:0]         arrival,
    input  logic [15:0]         burst,
    // output channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic                ran,
    output logic [3:0]          ran_slot,
    output logic [7:0]          ran_label,
    output logic                finished,
    output logic [20:0]         turnaround,
    output logic [20:0]         waiting,
    output logic                all_done,
    output logic [20:0]         time_after,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                cmd_reg;
    logic [NPROC_W-1:0]  nproc_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [CNT_W-1:0]    active_cnt;

    logic                in_fire;
    logic                out_free;
    logic                fin_fire;
    logic                load_ok;

    cell_ctl_t           ctl;
    cand_t               chain [SLOTS+1];
    cand_t               win;

    logic [TIME_W-1:0]   time_inc;
    logic [TIME_W-1:0]   tat;
    logic [TIME_W-1:0]   burst_w;
    logic                fin_now;
    logic [CNT_W-1:0]    undone_after;

    // Result register
    logic                out_valid_reg;
    logic                ran_reg;
    logic [3:0]          ran_slot_reg;
    logic [7:0]          ran_label_reg;
    logic                finished_reg;
    logic [20:0]         turnaround_reg;
    logic [20:0]         waiting_reg;
    logic                all_done_reg;
    logic [20:0]         time_after_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nproc_reg <= NPROC_RESET;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_NUM_PROC))
        begin
            nproc_reg <= pwdata[NPROC_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_NUM_PROC) ? {{(DATA_W - NPROC_W){1'b0}}, nproc_reg} : '0;

    assign active_cnt = (int'(nproc_reg) > SLOTS) ? SLOTS_CNT : CNT_W'(nproc_reg);

    // Handshake
    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign fin_fire = (state_reg == ST_FIN) && out_free;
    assign load_ok  = in_fire && (cmd == CMD_LOAD) &&
                      ({1'b0, slot} < 5'(SLOTS));

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == CNT_W'(SLOTS - 1))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= cmd;
        end
    end

    // Broadcast controls to the cells
    assign win = chain[SLOTS];

    always_comb
    begin
        ctl.wr_en      = load_ok;
        ctl.wr_slot    = SLOT_W'(slot);
        ctl.wr_label   = task_label;
        ctl.wr_arrival = arrival;
        ctl.wr_burst   = burst;
        ctl.run_en     = fin_fire && (cmd_reg == CMD_TICK) && win.found;
        ctl.run_slot   = win.slot;
        ctl.time_now   = time_reg;
        ctl.active_cnt = active_cnt;
    end

    // Cell chain; the head sees an empty candidate
    assign chain[0] = '0;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        srtf_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .my_idx   (SLOT_W'(i)),
            .ctl      (ctl),
            .cand_in  (chain[i]),
            .cand_out (chain[i+1])
        );
    end

    // Time and completion arithmetic for the winning slot
    assign time_inc     = (time_reg == TIME_MAX) ? time_reg : time_reg + TIME_W'(1);
    assign fin_now      = win.found && (win.rem == VAL_W'(1));
    assign tat          = time_inc - {{(TIME_W - VAL_W){1'b0}}, win.arrival};
    assign burst_w      = {{(TIME_W - VAL_W){1'b0}}, win.burst};
    assign undone_after = win.undone - CNT_W'(fin_now && (cmd_reg == CMD_TICK));

    // Time counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
        end
        else if (load_ok)
        begin
            time_reg <= '0;
        end
        else if (fin_fire && (cmd_reg == CMD_TICK))
        begin
            time_reg <= time_inc;
        end
    end

    // Result register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register: payload
    always_ff @(posedge clk)
    begin
        if (fin_fire)
        begin
            all_done_reg <= (undone_after == '0);
            if (cmd_reg == CMD_TICK)
            begin
                ran_reg        <= win.found;
                ran_slot_reg   <= win.found ? 4'(win.slot) : 4'd0;
                ran_label_reg  <= win.found ? win.label : 8'd0;
                finished_reg   <= fin_now;
                turnaround_reg <= fin_now ? tat : '0;
                waiting_reg    <= (fin_now && (tat >= burst_w)) ? (tat - burst_w) : '0;
                time_after_reg <= time_inc;
            end
            else
            begin
                ran_reg        <= 1'b0;
                ran_slot_reg   <= 4'd0;
                ran_label_reg  <= 8'd0;
                finished_reg   <= 1'b0;
                turnaround_reg <= '0;
                waiting_reg    <= '0;
                time_after_reg <= time_reg;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign ran        = ran_reg;
    assign ran_slot   = ran_slot_reg;
    assign ran_label  = ran_label_reg;
    assign finished   = finished_reg;
    assign turnaround = turnaround_reg;
    assign waiting    = waiting_reg;
    assign all_done   = all_done_reg;
    assign time_after = time_after_reg;

endmodule
